/* rtl/wrfd_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted relative feature distance: shared package
// Codes, fixed widths and the divider's control types used by all files.
// ----------------------------------------------------------------------------
package wrfd_pkg;

  localparam int NUM_W  = 72;   // dividend width of the shared divider
  localparam int DEN_W  = 48;   // divisor and remainder width
  localparam int STEP_W = 7;    // wide enough for the longest division
  localparam int MUL_W  = 32;   // operand width of the shared multiplier

  localparam logic [STEP_W-1:0] REL_STEPS   = 7'd25;
  localparam logic [STEP_W-1:0] GROUP_STEPS = 7'd57;
  localparam logic [STEP_W-1:0] FINAL_STEPS = 7'd72;

  localparam logic [1:0] KIND_PRED = 2'd0;
  localparam logic [1:0] KIND_FUNC = 2'd1;
  localparam logic [1:0] KIND_FEAT = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ZERO_WEIGHT = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW    = 2'd2;

  localparam logic [1:0] REG_PRED_WEIGHT = 2'd0;
  localparam logic [1:0] REG_FUNC_WEIGHT = 2'd1;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/wrfd_div.sv */
// ----------------------------------------------------------------------------
// Weighted relative feature distance: restoring divider
// One quotient bit per cycle; the dividend is fed in left-aligned and the
// remainder may be preloaded with a prefix known to lie below the divisor.
// ----------------------------------------------------------------------------
module wrfd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  wrfd_pkg::div_cmd_t            cmd,
  input  logic [wrfd_pkg::NUM_W-1:0]    num_init,
  input  logic [wrfd_pkg::DEN_W-1:0]    rem_init,
  input  logic [wrfd_pkg::DEN_W-1:0]    den,
  output wrfd_pkg::div_stat_t           stat,
  output logic [wrfd_pkg::NUM_W-1:0]    quo
);

  logic [wrfd_pkg::NUM_W-1:0]  num_sh;
  logic [wrfd_pkg::DEN_W-1:0]  rem;
  logic [wrfd_pkg::DEN_W-1:0]  den_reg;
  logic [wrfd_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [wrfd_pkg::DEN_W:0]    trial;
  logic [wrfd_pkg::DEN_W:0]    diff;
  logic                        fits;

  assign trial = {rem, num_sh[wrfd_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_reg};
  assign fits  = trial >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy    <= 1'b1;
        cnt     <= cmd.steps;
        num_sh  <= num_init;
        rem     <= rem_init;
        den_reg <= den;
        quo     <= '0;
      end else if (busy) begin
        rem    <= fits ? diff[wrfd_pkg::DEN_W-1:0] : trial[wrfd_pkg::DEN_W-1:0];
        num_sh <= {num_sh[wrfd_pkg::NUM_W-2:0], 1'b0};
        quo    <= {quo[wrfd_pkg::NUM_W-2:0], fits};
        cnt    <= cnt - 1'b1;
        if (cnt == wrfd_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/weighted_relative_feature_distance.sv */
// ----------------------------------------------------------------------------
// Weighted relative feature distance
// Streams value pairs of two vectors, accumulates squared relative
// differences per group and gives sqrt(total / norm) on the last word.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in       | input     | in_valid / in_ready  | kind value_a value_b weight last
//  out      | output    | out_valid / out_ready| distance status
//  cfg      | input     | cfg_valid / cfg_ready| cfg_index cfg_data
//
// An arity or feature word runs the 25-step relative division in the shared
// divider plus multiplier passes; a pair of two zeros skips the division, as
// do ignored words. A word marked last adds two weight squarings, two group
// passes around 57-step divisions, a 72-step final division and a 17-step
// square root. Reset is synchronous and clears all accumulators; the weights
// return to 1.0. A result waiting on out_ready stalls the block only when the
// next last word is ready to be delivered.
module weighted_relative_feature_distance #(
  parameter int MAX_ARITY_ENTRIES = 64,
  parameter int FEATURE_COUNT     = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [31:0] value_a,
  input  logic signed [31:0] value_b,
  input  logic [15:0]        weight,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        distance,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CNT_W  = $clog2(MAX_ARITY_ENTRIES + 1);
  localparam int SUM_W  = $clog2(MAX_ARITY_ENTRIES * 65536 + 1);
  localparam int FEAT_W = $clog2(FEATURE_COUNT + 1);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_PREP   = 19'h00002,
    S_RDIV   = 19'h00004,
    S_RSQ    = 19'h00008,
    S_RRND   = 19'h00010,
    S_APPLY  = 19'h00020,
    S_FW1    = 19'h00040,
    S_FW2    = 19'h00080,
    S_FIN0   = 19'h00100,
    S_FIN1   = 19'h00200,
    S_FIN2   = 19'h00400,
    S_GSQ    = 19'h00800,
    S_GMUL   = 19'h01000,
    S_GDIVST = 19'h02000,
    S_GDIV   = 19'h04000,
    S_GNEXT  = 19'h08000,
    S_QDIV   = 19'h10000,
    S_SQRT   = 19'h20000,
    S_OUT    = 19'h40000
  } state_t;

  state_t state;

  logic [15:0]        pred_weight;
  logic [15:0]        func_weight;
  logic [SUM_W-1:0]   pred_square_sum;
  logic [SUM_W-1:0]   func_square_sum;
  logic [CNT_W-1:0]   pred_count;
  logic [CNT_W-1:0]   func_count;
  logic [FEAT_W-1:0]  feature_seen;
  logic [55:0]        weighted_total;
  logic [47:0]        norm_total;
  logic               overflow_seen;

  logic [1:0]         kind_reg;
  logic signed [31:0] a_reg;
  logic signed [31:0] b_reg;
  logic [15:0]        w_reg;
  logic               last_reg;

  logic [16:0]        rsq;
  logic [31:0]        pwsq;
  logic [31:0]        fwsq;
  logic [16:0]        nn;
  logic               grp;
  logic [16:0]        res_dist;
  logic [1:0]         res_status;

  logic [33:0]        sq_x;
  logic [33:0]        sq_res;
  logic [33:0]        sq_bit;

  logic [wrfd_pkg::MUL_W-1:0]   mul_a;
  logic [wrfd_pkg::MUL_W-1:0]   mul_b;
  logic [2*wrfd_pkg::MUL_W-1:0] prod;

  wrfd_pkg::div_cmd_t           div_cmd;
  wrfd_pkg::div_stat_t          div_stat;
  logic [wrfd_pkg::NUM_W-1:0]   div_num;
  logic [wrfd_pkg::DEN_W-1:0]   div_rem;
  logic [wrfd_pkg::DEN_W-1:0]   div_den;
  logic [wrfd_pkg::NUM_W-1:0]   div_quo;

  // Relative difference operands.
  logic [32:0] mag_a;
  logic [32:0] mag_b;
  logic [32:0] mmax;
  logic [33:0] diff_ab;
  logic [33:0] dmag;
  logic [32:0] den_rel;
  logic        slot_free;
  logic        arity_full;

  logic [CNT_W-1:0] cnt_g;
  logic [SUM_W-1:0] sum_g;
  logic [31:0]      wsq_g;

  logic [48:0] rnd_sum;
  logic [33:0] sq_sum;
  logic        sq_ge;
  logic [33:0] sq_res_new;
  logic [32:0] q_clamped;

  always_comb begin
    mag_a   = a_reg[31] ? 33'(-{a_reg[31], a_reg}) : {1'b0, a_reg};
    mag_b   = b_reg[31] ? 33'(-{b_reg[31], b_reg}) : {1'b0, b_reg};
    mmax    = (mag_a > mag_b) ? mag_a : mag_b;
    diff_ab = {{2{a_reg[31]}}, a_reg} - {{2{b_reg[31]}}, b_reg};
    dmag    = diff_ab[33] ? 34'(-diff_ab) : diff_ab;
    den_rel = {mmax[31:0], 1'b0};
  end

  always_comb begin
    slot_free  = 1'b0;
    arity_full = 1'b0;
    case (kind_reg)
      wrfd_pkg::KIND_PRED: begin
        arity_full = pred_count == CNT_W'(MAX_ARITY_ENTRIES);
        slot_free  = !arity_full;
      end
      wrfd_pkg::KIND_FUNC: begin
        arity_full = func_count == CNT_W'(MAX_ARITY_ENTRIES);
        slot_free  = !arity_full;
      end
      wrfd_pkg::KIND_FEAT: slot_free = feature_seen < FEAT_W'(FEATURE_COUNT);
      default:             slot_free = 1'b0;
    endcase
  end

  assign cnt_g = grp ? func_count : pred_count;
  assign sum_g = grp ? func_square_sum : pred_square_sum;
  assign wsq_g = grp ? fwsq : pwsq;

  assign rnd_sum    = prod[48:0] + 49'h0_8000_0000;
  assign sq_sum     = sq_res + sq_bit;
  assign sq_ge      = sq_x >= sq_sum;
  assign sq_res_new = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  // The quotient is limited to 1.0 in Q1.32 before the root.
  assign q_clamped = ((|div_quo[71:33]) || (div_quo[32] && (|div_quo[31:0])))
                     ? 33'h1_0000_0000 : div_quo[32:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_RSQ: begin
        mul_a = 32'(div_quo[24:0]);
        mul_b = 32'(div_quo[24:0]);
      end
      S_APPLY: begin
        mul_a = 32'(w_reg);
        mul_b = 32'(w_reg);
      end
      S_FW1: begin
        mul_a = 32'(rsq);
        mul_b = prod[31:0];
      end
      S_FIN0: begin
        mul_a = 32'(pred_weight);
        mul_b = 32'(pred_weight);
      end
      S_FIN1: begin
        mul_a = 32'(func_weight);
        mul_b = 32'(func_weight);
      end
      S_GSQ: begin
        mul_a = 32'(cnt_g);
        mul_b = 32'(cnt_g);
      end
      S_GMUL: begin
        mul_a = 32'(sum_g);
        mul_b = wsq_g;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Divider command and operands.
  always_comb begin
    div_cmd.start = 1'b0;
    div_cmd.steps = wrfd_pkg::REL_STEPS;
    div_num       = '0;
    div_rem       = '0;
    div_den       = '0;
    unique case (state)
      S_PREP: begin
        div_cmd.start = slot_free && (mmax != 33'd0);
        div_num       = {dmag[0], 71'd0};
        div_rem       = 48'(dmag[32:1]);
        div_den       = 48'(den_rel);
      end
      S_GDIVST: begin
        div_cmd.start = cnt_g != '0;
        div_cmd.steps = wrfd_pkg::GROUP_STEPS;
        div_num       = {prod[56:0], 15'd0};
        div_den       = 48'(nn);
      end
      S_GNEXT: begin
        div_cmd.start = grp && !overflow_seen && (norm_total != 48'd0);
        div_cmd.steps = wrfd_pkg::FINAL_STEPS;
        div_num       = {weighted_total, 16'd0};
        div_den       = norm_total;
      end
      default: div_cmd.start = 1'b0;
    endcase
  end

  wrfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .num_init (div_num),
    .rem_init (div_rem),
    .den      (div_den),
    .stat     (div_stat),
    .quo      (div_quo)
  );

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pred_weight     <= 16'd256;
      func_weight     <= 16'd256;
      pred_square_sum <= '0;
      func_square_sum <= '0;
      pred_count      <= '0;
      func_count      <= '0;
      feature_seen    <= '0;
      weighted_total  <= '0;
      norm_total      <= '0;
      overflow_seen   <= 1'b0;
      out_valid       <= 1'b0;
      grp             <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wrfd_pkg::REG_PRED_WEIGHT: pred_weight <= cfg_data;
          wrfd_pkg::REG_FUNC_WEIGHT: func_weight <= cfg_data;
          default: ;
        endcase
      end

      // In S_OUT the output register is reloaded below instead.
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_reg <= kind;
            a_reg    <= value_a;
            b_reg    <= value_b;
            w_reg    <= weight;
            last_reg <= last;
            state    <= S_PREP;
          end
        end
        S_PREP: begin
          if (arity_full) begin
            overflow_seen <= 1'b1;
          end
          if (!slot_free) begin
            state <= last_reg ? S_FIN0 : S_IDLE;
          end else if (mmax == 33'd0) begin
            rsq   <= '0;
            state <= S_APPLY;
          end else begin
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_stat.done) begin
            state <= S_RSQ;
          end
        end
        S_RSQ: state <= S_RRND;
        S_RRND: begin
          rsq   <= rnd_sum[48:32];
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (kind_reg == wrfd_pkg::KIND_FEAT) begin
            state <= S_FW1;
          end else begin
            if (kind_reg == wrfd_pkg::KIND_PRED) begin
              pred_square_sum <= pred_square_sum + SUM_W'(rsq);
              pred_count      <= pred_count + 1'b1;
            end else begin
              func_square_sum <= func_square_sum + SUM_W'(rsq);
              func_count      <= func_count + 1'b1;
            end
            state <= last_reg ? S_FIN0 : S_IDLE;
          end
        end
        S_FW1: begin
          norm_total <= norm_total + 48'(prod[31:0]);
          state      <= S_FW2;
        end
        S_FW2: begin
          weighted_total <= weighted_total + prod[55:0];
          feature_seen   <= feature_seen + 1'b1;
          state          <= last_reg ? S_FIN0 : S_IDLE;
        end
        S_FIN0: state <= S_FIN1;
        S_FIN1: begin
          pwsq  <= prod[31:0];
          state <= S_FIN2;
        end
        S_FIN2: begin
          fwsq       <= prod[31:0];
          norm_total <= norm_total + 48'(pwsq) + 48'(prod[31:0]);
          grp        <= 1'b0;
          state      <= S_GSQ;
        end
        S_GSQ: state <= S_GMUL;
        S_GMUL: begin
          nn    <= prod[16:0];
          state <= S_GDIVST;
        end
        S_GDIVST: state <= (cnt_g != '0) ? S_GDIV : S_GNEXT;
        S_GDIV: begin
          if (div_stat.done) begin
            weighted_total <= weighted_total + div_quo[55:0];
            state          <= S_GNEXT;
          end
        end
        S_GNEXT: begin
          if (!grp) begin
            grp   <= 1'b1;
            state <= S_GSQ;
          end else if (overflow_seen) begin
            res_dist   <= '0;
            res_status <= wrfd_pkg::STATUS_OVERFLOW;
            state      <= S_OUT;
          end else if (norm_total == 48'd0) begin
            res_dist   <= '0;
            res_status <= wrfd_pkg::STATUS_ZERO_WEIGHT;
            state      <= S_OUT;
          end else begin
            state <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (div_stat.done) begin
            sq_x   <= 34'(q_clamped);
            sq_res <= '0;
            sq_bit <= 34'h1_0000_0000;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_x <= sq_x - sq_sum;
          end
          sq_res <= sq_res_new;
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 34'd1) begin
            res_dist   <= sq_res_new[16:0];
            res_status <= wrfd_pkg::STATUS_OK;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            distance        <= res_dist;
            status          <= res_status;
            out_valid       <= 1'b1;
            pred_square_sum <= '0;
            func_square_sum <= '0;
            pred_count      <= '0;
            func_count      <= '0;
            feature_seen    <= '0;
            weighted_total  <= '0;
            norm_total      <= '0;
            overflow_seen   <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_dist_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != wrfd_pkg::STATUS_OK) |-> distance == 17'd0)
    else $error("distance not zero on an error word");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    div_cmd.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (pred_count <= CNT_W'(MAX_ARITY_ENTRIES)) &&
    (func_count <= CNT_W'(MAX_ARITY_ENTRIES)))
    else $error("arity count beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new word taken while one is in progress");
`endif

endmodule

/* verif/tb_weighted_relative_feature_distance.sv */
// ----------------------------------------------------------------------------
// Testbench for the weighted relative feature distance block
// Streams vector comparisons under random idling and back-pressure, predicts
// each distance and status word in its own model of the block, and compares
// every delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_weighted_relative_feature_distance;

  localparam int ARITY_CAP  = 64;
  localparam int FEAT_CAP   = 15;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 3000;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [16:0] dist_val;
    logic [1:0]  stat;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         kind = wrfd_pkg::KIND_PRED;
  logic signed [31:0] value_a = '0;
  logic signed [31:0] value_b = '0;
  logic [15:0]        weight = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [16:0]        distance;
  logic [1:0]         status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = wrfd_pkg::REG_PRED_WEIGHT;
  logic [15:0]        cfg_data = '0;

  weighted_relative_feature_distance dut (.*);

  always #4 clk = ~clk;

  // Predictor state.
  longint unsigned pw = 256, fw = 256;
  longint unsigned p_sum = 0, f_sum = 0, feat_total = 0, norm_sum = 0;
  int unsigned     p_cnt = 0, f_cnt = 0, feat_cnt = 0;
  bit              arity_overflow = 1'b0;
  result_t         pending_results[$];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned hold_cycles = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;

  function automatic longint unsigned rel_diff_sq(logic signed [31:0] a, logic signed [31:0] b);
    longint signed   sa, sb;
    longint unsigned ma, mb, m, d, q;
    sa = a;
    sb = b;
    ma = sa < 0 ? -sa : sa;
    mb = sb < 0 ? -sb : sb;
    m  = ma > mb ? ma : mb;
    if (m == 0) return 0;
    d = (sa - sb) < 0 ? sb - sa : sa - sb;
    q = (d << 24) / (2 * m);
    return (q * q + (64'd1 << 31)) >> 32;
  endfunction

  function automatic longint unsigned arity_term(longint unsigned s, int unsigned n,
                                                 longint unsigned wsq);
    if (n == 0) return 0;
    return (s * wsq) / (longint'(n) * n);
  endfunction

  function automatic longint unsigned root_q16(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int i = 16; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  task automatic clear_sums();
    p_sum = 0; f_sum = 0; p_cnt = 0; f_cnt = 0;
    feat_total = 0; norm_sum = 0; feat_cnt = 0; arity_overflow = 0;
  endtask

  task automatic predict_word(logic [1:0] k, logic signed [31:0] a, logic signed [31:0] b,
                              logic [15:0] w, logic l);
    longint unsigned total, norm, q, rem;
    result_t r;
    case (k)
      wrfd_pkg::KIND_PRED: begin
        if (p_cnt >= ARITY_CAP) arity_overflow = 1;
        else begin p_sum += rel_diff_sq(a, b); p_cnt++; end
      end
      wrfd_pkg::KIND_FUNC: begin
        if (f_cnt >= ARITY_CAP) arity_overflow = 1;
        else begin f_sum += rel_diff_sq(a, b); f_cnt++; end
      end
      wrfd_pkg::KIND_FEAT: begin
        if (feat_cnt < FEAT_CAP) begin
          feat_total += rel_diff_sq(a, b) * (longint'(w) * w);
          norm_sum += longint'(w) * w;
          feat_cnt++;
        end
      end
      default: ;
    endcase
    if (!l) return;
    total = feat_total + arity_term(p_sum, p_cnt, pw * pw) + arity_term(f_sum, f_cnt, fw * fw);
    norm  = norm_sum + pw * pw + fw * fw;
    if (arity_overflow) r = '{dist_val: '0, stat: wrfd_pkg::STATUS_OVERFLOW};
    else if (norm == 0) r = '{dist_val: '0, stat: wrfd_pkg::STATUS_ZERO_WEIGHT};
    else begin
      q = total / norm;
      rem = total % norm;
      for (int i = 0; i < 16; i++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= norm) begin rem -= norm; q |= 1; end
      end
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      q = root_q16(q);
      if (q > 65536) q = 65536;
      r = '{dist_val: q[16:0], stat: wrfd_pkg::STATUS_OK};
    end
    pending_results.push_back(r);
    clear_sums();
  endtask

  // Prediction, checking and watchdog, all on the sampled pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles = idle_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        idle_cycles = 0;
        if (cfg_index == wrfd_pkg::REG_PRED_WEIGHT) pw = cfg_data;
        else if (cfg_index == wrfd_pkg::REG_FUNC_WEIGHT) fw = cfg_data;
      end
      if (in_valid && in_ready) begin
        idle_cycles = 0;
        predict_word(kind, value_a, value_b, weight, last);
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: distance %0d status %0d", distance, status);
        end else begin
          result_t e;
          e = pending_results.pop_front();
          if (e.dist_val !== distance || e.stat !== status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: distance exp %0d got %0d, status exp %0d got %0d",
                       e.dist_val, distance, e.stat, status);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: switches between always ready, random stalls and heavy stalls;
  // a requested hold-off overrides all of them.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_word(logic [1:0] k, logic signed [31:0] a, logic signed [31:0] b,
                           logic [15:0] w, logic l);
    if (burst_left == 0) begin
      if (in_valid && $urandom_range(0, 1)) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    kind <= k; value_a <= a; value_b <= b; weight <= w; last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every pending result, then for any ignored word still in flight.
  task automatic drain();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return $urandom_range(0, 4096) - 2048;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // One vector comparison with random group sizes and contents.
  task automatic send_vector(int unsigned np, int unsigned nf, int unsigned nx, bit noise);
    int unsigned total, n;
    logic signed [31:0] a, b;
    logic [1:0] k;
    total = np + nf + nx;
    n = 0;
    if (total == 0) begin
      send_word(KIND_NONE, pick_value(), pick_value(), pick_weight(), 1'b1);
      return;
    end
    for (int i = 0; i < total; i++) begin
      k = i < np ? wrfd_pkg::KIND_PRED
                 : (i < np + nf ? wrfd_pkg::KIND_FUNC : wrfd_pkg::KIND_FEAT);
      if (noise && $urandom_range(0, 9) == 0) k = 2'($urandom_range(0, 3));
      a = pick_value();
      case ($urandom_range(0, 5))
        0: b = a;
        1: b = -a;
        default: b = pick_value();
      endcase
      send_word(k, a, b, pick_weight(), i == total - 1);
    end
  endtask

  task automatic test_directed_extremes();
    send_word(wrfd_pkg::KIND_PRED, 32'sh8000_0000, 32'sh7fff_ffff, 16'd0, 1'b0);
    send_word(wrfd_pkg::KIND_FUNC, 32'sh7fff_ffff, 32'sh8000_0000, 16'hffff, 1'b0);
    send_word(wrfd_pkg::KIND_FEAT, 32'sh0, 32'sh8000_0000, 16'hffff, 1'b0);
    send_word(wrfd_pkg::KIND_FEAT, 32'sh0, 32'sh0, 16'd256, 1'b1);
    // Unknown kind alone: groups empty, weights still give a non-zero norm.
    send_word(KIND_NONE, 32'sh1234, -32'sh1234, 16'hffff, 1'b1);
    // Features only, arity groups empty.
    send_word(wrfd_pkg::KIND_FEAT, 32'sh100, 32'sh300, 16'h1234, 1'b1);
    send_word(wrfd_pkg::KIND_PRED, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'd0, 1'b1);
    send_word(wrfd_pkg::KIND_FUNC, -32'sh5, 32'sh5, 16'd0, 1'b1);
    drain();
  endtask

  task automatic test_zero_norm();
    write_reg(wrfd_pkg::REG_PRED_WEIGHT, 16'd0);
    write_reg(wrfd_pkg::REG_FUNC_WEIGHT, 16'd0);
    send_word(wrfd_pkg::KIND_PRED, 32'sh100, 32'sh50, 16'hffff, 1'b0);
    send_word(wrfd_pkg::KIND_FEAT, 32'sh100, 32'sh50, 16'd0, 1'b1);
    send_word(KIND_NONE, 32'sh0, 32'sh0, 16'd0, 1'b1);
    drain();
    write_reg(wrfd_pkg::REG_PRED_WEIGHT, 16'd256);
    write_reg(wrfd_pkg::REG_FUNC_WEIGHT, 16'd256);
  endtask

  task automatic test_overflow_and_excess_features();
    // A predicate group one past capacity, a function group two past it, and a feature group past its limit.
    send_vector(ARITY_CAP + 1, 2, 1, 1'b0);
    send_vector(0, ARITY_CAP + 2, 0, 1'b0);
    send_vector(ARITY_CAP, ARITY_CAP, FEAT_CAP + 3, 1'b0);
    drain();
  endtask

  task automatic test_weight_settings();
    logic [15:0] wp[4] = '{16'd0, 16'hffff, 16'd1, 16'h0080};
    logic [15:0] wf[4] = '{16'hffff, 16'd0, 16'hffff, 16'h8000};
    for (int s = 0; s < 5; s++) begin
      write_reg(wrfd_pkg::REG_PRED_WEIGHT, s < 4 ? wp[s] : 16'($urandom));
      write_reg(wrfd_pkg::REG_FUNC_WEIGHT, s < 4 ? wf[s] : 16'($urandom));
      repeat (8) send_vector($urandom_range(0, 6), $urandom_range(0, 6),
                             $urandom_range(0, 8), 1'b0);
      drain();
    end
    write_reg(wrfd_pkg::REG_PRED_WEIGHT, 16'd256);
    write_reg(wrfd_pkg::REG_FUNC_WEIGHT, 16'd256);
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_req <= ~hold_req;
    repeat (20) send_vector(0, 0, $urandom_range(0, 2), 1'b0);
    drain();
  endtask

  task automatic test_random_vectors();
    int unsigned sent;
    sent = 0;
    while (sent < 550) begin
      int unsigned np, nf, nx;
      if ($urandom_range(0, 39) == 0) np = $urandom_range(60, 70);
      else np = $urandom_range(0, 8);
      nf = $urandom_range(0, 8);
      nx = $urandom_range(0, 17);
      send_vector(np, nf, nx, $urandom_range(0, 4) == 0);
      sent += np + nf + nx + 1;
      if ($urandom_range(0, 29) == 0) begin
        drain();
        write_reg(wrfd_pkg::REG_PRED_WEIGHT, pick_weight());
        write_reg(wrfd_pkg::REG_FUNC_WEIGHT, pick_weight());
      end
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_zero_norm();
    test_overflow_and_excess_features();
    test_weight_settings();
    test_backpressure();
    test_random_vectors();
    if (errors == 0 && pending_results.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/wrfd_pkg.sv
rtl/wrfd_div.sv
rtl/weighted_relative_feature_distance.sv
verif/tb_weighted_relative_feature_distance.sv
